// ----- rtl/huffman_tree_table_decoder_top_assert.svh -----
// Assertion macros for the Huffman tree-table decoder checker.
// No dependencies; included by the checker file only.
`ifndef HUFFMAN_TREE_TABLE_DECODER_TOP_ASSERT_SVH
`define HUFFMAN_TREE_TABLE_DECODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define HTD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define HTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/htd_pkg.sv -----
// Shared types and constants for the Huffman tree-table decoder.
// No dependencies; used by every module of the block but htd_ram.
package htd_pkg;

  localparam int TABLE_DEPTH_DEF = 512;
  localparam int SYMBOL_BITS     = 8;
  localparam int WORD_BITS       = 16;
  localparam int IDX_BITS        = 9;
  localparam int NODE_BITS       = 2 * IDX_BITS;
  localparam int POS_BITS        = 4;
  localparam int COUNT_BITS      = 5;

  // input tdata field layout, lowest bit first
  localparam int IN_ENTRY_LSB    = 0;
  localparam int IN_BZERO_LSB    = IN_ENTRY_LSB + IDX_BITS;
  localparam int IN_BONE_LSB     = IN_BZERO_LSB + IDX_BITS;
  localparam int IN_CODE_LSB     = IN_BONE_LSB + IDX_BITS;
  localparam int IN_FIRST_LSB    = IN_CODE_LSB + WORD_BITS;
  localparam int IN_COUNT_LSB    = IN_FIRST_LSB + POS_BITS;
  localparam int IN_RESTART_LSB  = IN_COUNT_LSB + COUNT_BITS;
  localparam int IN_USED_BITS    = IN_RESTART_LSB + 1;
  localparam int S_TDATA_BITS    = ((IN_USED_BITS + 7) / 8) * 8;
  localparam int M_TDATA_BITS    = ((SYMBOL_BITS + 7) / 8) * 8;

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic take_write;  // store one node
    logic take_word;   // latch a code word
    logic issue;       // consume one bit, start a table read
    logic eval;        // act on the table read result
    logic flush;       // send the held symbol as last of word
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  start_empty;  // incoming word has no bits to walk
    logic  more;         // bits left to issue
    logic  leaf;         // table read result is a leaf
    logic  pend_valid;   // a symbol is held back
    logic  out_free;     // output register can load
  } status_t;

endpackage

// ----- rtl/htd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htd_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/htd_ctrl.sv -----
// Sequencer for the Huffman tree-table decoder.
// Depends on htd_pkg (state, command and status types).
module htd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  htd_pkg::status_t status_i,
  output htd_pkg::cmd_t    cmd_o
);

  htd_pkg::state_e state_q, state_d;
  logic            stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a second leaf cannot replace the held one until the output can load
  assign stall = status_i.leaf && status_i.pend_valid && !status_i.out_free;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      htd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.mode == htd_pkg::MODE_WRITE) begin
            cmd_o.take_write = 1'b1;
          end else begin
            cmd_o.take_word = 1'b1;
            if (!status_i.start_empty) begin
              state_d = htd_pkg::ST_LOAD;
            end
          end
        end
      end
      htd_pkg::ST_LOAD: begin
        cmd_o.issue = 1'b1;
        state_d     = htd_pkg::ST_STEP;
      end
      htd_pkg::ST_STEP: begin
        if (!stall) begin
          cmd_o.eval = 1'b1;
          if (status_i.more) begin
            cmd_o.issue = 1'b1;
          end else begin
            state_d = htd_pkg::ST_FLUSH;
          end
        end
      end
      htd_pkg::ST_FLUSH: begin
        if (!status_i.pend_valid) begin
          state_d = htd_pkg::ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = htd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = htd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/htd_datapath.sv -----
// Datapath for the Huffman tree-table decoder: node table, walk registers,
// held symbol and output register. Depends on htd_pkg and htd_ram.
module htd_datapath #(
  parameter int TABLE_DEPTH = htd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  htd_pkg::cmd_t                    cmd_i,
  output htd_pkg::status_t                 status_o,
  input  logic                             mode_i,
  input  logic [htd_pkg::IDX_BITS-1:0]     entry_index_i,
  input  logic [htd_pkg::IDX_BITS-1:0]     branch_zero_i,
  input  logic [htd_pkg::IDX_BITS-1:0]     branch_one_i,
  input  logic [htd_pkg::WORD_BITS-1:0]    code_word_i,
  input  logic [htd_pkg::POS_BITS-1:0]     first_bit_i,
  input  logic [htd_pkg::COUNT_BITS-1:0]   bit_count_i,
  input  logic                             restart_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [htd_pkg::SYMBOL_BITS-1:0]  out_symbol_o,
  output logic                             out_last_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = htd_pkg::IDX_BITS;
  localparam logic [htd_pkg::COUNT_BITS-1:0] WORD_LEN =
    htd_pkg::COUNT_BITS'(htd_pkg::WORD_BITS);

  // walk state
  logic [htd_pkg::NODE_BITS-1:0]   root_q, cur_q;
  logic [IW-1:0]                   cur_idx_q, rd_idx_q;
  logic                            rd_in_range_q;
  logic [htd_pkg::WORD_BITS-1:0]   word_q;
  logic [htd_pkg::COUNT_BITS-1:0]  remain_q;
  logic                            pend_valid_q;
  logic [htd_pkg::SYMBOL_BITS-1:0] pend_sym_q;
  logic                            out_valid_q, out_last_q;
  logic [htd_pkg::SYMBOL_BITS-1:0] out_sym_q;

  logic [htd_pkg::NODE_BITS-1:0]   ram_rdata, node_eff, cur_now, node_wr;
  logic                            leaf, out_free, push, wr_in_range, wr_en;
  logic [IW-1:0]                   next_idx;
  logic [31:0]                     next_ext, entry_ext;
  logic [htd_pkg::COUNT_BITS-1:0]  avail, remain_in;

  assign node_wr     = {branch_one_i, branch_zero_i};
  assign entry_ext   = 32'(entry_index_i);
  assign wr_in_range = entry_ext < 32'(TABLE_DEPTH);
  assign wr_en       = cmd_i.take_write && wr_in_range;

  // reads past the table see an all-zero node, a leaf with symbol zero
  assign node_eff = rd_in_range_q ? ram_rdata : '0;
  assign leaf     = (node_eff[IW-1:0] == '0);

  // current node after this cycle's evaluation feeds the next address
  always_comb begin
    cur_now = cur_q;
    if (cmd_i.eval) begin
      cur_now = leaf ? root_q : node_eff;
    end
  end

  assign next_idx = word_q[0] ? cur_now[2*IW-1:IW] : cur_now[IW-1:0];
  assign next_ext = 32'(next_idx);

  assign avail     = WORD_LEN - {1'b0, first_bit_i};
  assign remain_in = (bit_count_i > avail) ? avail : bit_count_i;

  assign out_free = !out_valid_q || out_ready_i;
  assign push     = (cmd_i.eval && leaf && pend_valid_q) || cmd_i.flush;

  htd_ram #(
    .WIDTH(htd_pkg::NODE_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(entry_ext[AW-1:0]),
    .wdata_i(node_wr),
    .re_i   (cmd_i.issue),
    .raddr_i(next_ext[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_idx_q    <= '0;
      remain_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.take_word) begin
        remain_q <= remain_in;
        if (restart_i) begin
          cur_idx_q <= '0;
        end
      end
      if (cmd_i.eval) begin
        cur_idx_q <= leaf ? '0 : rd_idx_q;
        if (leaf) begin
          pend_valid_q <= 1'b1;
        end
      end
      if (cmd_i.issue) begin
        remain_q <= remain_q - 1'b1;
      end
      if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      // keep cached copies of the root and the current node coherent
      if (entry_index_i == '0) begin
        root_q <= node_wr;
      end
      if (entry_index_i == cur_idx_q) begin
        cur_q <= node_wr;
      end
    end
    if (cmd_i.take_word) begin
      word_q <= code_word_i >> first_bit_i;
      if (restart_i) begin
        cur_q <= root_q;
      end
    end
    if (cmd_i.eval) begin
      cur_q <= cur_now;
      if (leaf) begin
        pend_sym_q <= node_eff[IW +: htd_pkg::SYMBOL_BITS];
      end
    end
    if (cmd_i.issue) begin
      rd_idx_q      <= next_idx;
      rd_in_range_q <= next_ext < 32'(TABLE_DEPTH);
      word_q        <= word_q >> 1;
    end
    if (push) begin
      out_sym_q  <= pend_sym_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign status_o.mode        = htd_pkg::mode_e'(mode_i);
  assign status_o.start_empty = (remain_in == '0);
  assign status_o.more        = (remain_q != '0);
  assign status_o.leaf        = leaf;
  assign status_o.pend_valid  = pend_valid_q;
  assign status_o.out_free    = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- rtl/huffman_tree_table_decoder_top.sv -----
// Top level of the Huffman tree-table decoder: stream ports, field unpacking,
// sequencer and datapath. Depends on htd_pkg, htd_ctrl, htd_datapath, htd_ram.
//
//   channel  | direction | payload
//   ---------+-----------+---------------------------------------------------
//   s_axis   | in        | tuser = mode; tdata = entry_index, branch_zero,
//            |           |   branch_one, code_word, first_bit, bit_count, restart
//   m_axis   | out       | tdata = symbol; tlast = last_of_word
//
// A table-write item, like a decode item with no bits to walk, is taken in
// ST_IDLE alone. A decode item with walked bits goes through accept, first
// read, one step per bit and flush, each step set by the one dependent
// node-table read per bit through the single RAM read port.
// Reset clears the walk to entry 0 and empties the output; table contents stay
// undefined until written. A stalled m_axis holds the walk at the next leaf.
module huffman_tree_table_decoder_top #(
  parameter int TABLE_DEPTH = htd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [8:0] entry_index, [17:9] branch_zero, [26:18] branch_one,
  // [42:27] code_word, [46:43] first_bit, [51:47] bit_count, [52] restart
  input  logic [htd_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
  // [0] mode
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] symbol
  output logic [htd_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast
);

  htd_pkg::cmd_t                   cmd;
  htd_pkg::status_t                status;
  logic [htd_pkg::SYMBOL_BITS-1:0] symbol;

  htd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // unpack the input item straight out of tdata
  htd_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .mode_i       (s_axis_tuser[0]),
    .entry_index_i(s_axis_tdata[htd_pkg::IN_ENTRY_LSB +: htd_pkg::IDX_BITS]),
    .branch_zero_i(s_axis_tdata[htd_pkg::IN_BZERO_LSB +: htd_pkg::IDX_BITS]),
    .branch_one_i (s_axis_tdata[htd_pkg::IN_BONE_LSB +: htd_pkg::IDX_BITS]),
    .code_word_i  (s_axis_tdata[htd_pkg::IN_CODE_LSB +: htd_pkg::WORD_BITS]),
    .first_bit_i  (s_axis_tdata[htd_pkg::IN_FIRST_LSB +: htd_pkg::POS_BITS]),
    .bit_count_i  (s_axis_tdata[htd_pkg::IN_COUNT_LSB +: htd_pkg::COUNT_BITS]),
    .restart_i    (s_axis_tdata[htd_pkg::IN_RESTART_LSB]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_symbol_o (symbol),
    .out_last_o   (m_axis_tlast)
  );

  // symbol zero-filled to whole bytes
  assign m_axis_tdata = htd_pkg::M_TDATA_BITS'(symbol);

endmodule

// ----- rtl/htd_checker.sv -----
// Port-level checker for the Huffman tree-table decoder, bound to the top.
// Depends on htd_pkg and huffman_tree_table_decoder_top_assert.svh.
`include "huffman_tree_table_decoder_top_assert.svh"

module htd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [htd_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
  input logic [0:0]                       s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [htd_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);

  logic                           s_acc;
  logic                           word_has_bits;
  logic                           out_stall;
  logic [htd_pkg::M_TDATA_BITS:0] out_pl;
  logic                           wr_acc_idle;
  logic                           walk_acc;

  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign word_has_bits =
    s_axis_tdata[htd_pkg::IN_COUNT_LSB +: htd_pkg::COUNT_BITS] != '0;
  assign out_stall     = m_axis_tvalid && !m_axis_tready;
  assign out_pl        = {m_axis_tlast, m_axis_tdata};
  assign wr_acc_idle   = s_acc && (s_axis_tuser[0] == htd_pkg::MODE_WRITE) && !m_axis_tvalid;
  assign walk_acc      = s_acc && (s_axis_tuser[0] == htd_pkg::MODE_DECODE) && word_has_bits;

  // stalled result must hold
  `HTD_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_pl), "stalled output changed")

  // a table write never produces a result
  `HTD_ASSERT_NEXT(a_write_silent, wr_acc_idle, !m_axis_tvalid, "result after a table write")

  // a word with bits to walk keeps the input closed on the next cycle
  `HTD_ASSERT_NEXT(a_word_busy, walk_acc, !s_axis_tready, "input reopened during a walk")

  // results are only produced while a word is being walked
  `HTD_ASSERT_IMPL(a_out_walk, $rose(m_axis_tvalid), $past(!s_axis_tready), "result while idle")

endmodule

bind huffman_tree_table_decoder_top htd_checker u_htd_checker (.*);
